// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL; clock and reset are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/bpgc_pkg.sv =====
// Types and constants for the button press gesture classifier.
package bpgc_pkg;

   typedef enum logic [2:0] {
      GEST_REST       = 3'd0,
      GEST_PRESSED    = 3'd1,
      GEST_STILL      = 3'd2,
      GEST_LONG       = 3'd3,
      GEST_STILL_LONG = 3'd4,
      GEST_RELEASED   = 3'd5,
      GEST_DOUBLE     = 3'd6
   } gesture_type;

   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 15;
   localparam int TimeW    = 32;
   localparam int MsW      = 15;
   localparam int BtnIdxW  = 3;
   localparam int ScanW    = 4;
   localparam int FirstW   = 4;

   localparam logic [CsrIdxW-1:0] CSR_LONG_PRESS   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_DOUBLE_WIN   = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_BUTTONS_USED = 2'd2;

   localparam logic [MsW-1:0]   LONG_PRESS_RST   = 15'd500;
   localparam logic [MsW-1:0]   DOUBLE_WIN_RST   = 15'd300;
   localparam logic [ScanW-1:0] BUTTONS_USED_RST = 4'd8;

   // -1 in four bits: no button away from rest
   localparam logic [FirstW-1:0] FIRST_NONE = 4'hF;

   localparam int ReqDataW = 40;
   localparam int RspDataW = 8;

   // Outcome of one gesture update for the addressed button.
   typedef struct packed {
      gesture_type gesture;
      logic        time_wr;
   } adv_type;

   typedef struct packed {
      logic [FirstW-1:0] first_active;
      logic              any_active;
      gesture_type       new_gesture;
   } rsp_type;

endpackage

// ===== hdl/bpgc_advance.sv =====
// Next gesture state of one button from its current state, level and elapsed time.
module bpgc_advance (
   input  bpgc_pkg::gesture_type              cur_gesture,
   input  logic [bpgc_pkg::TimeW-1:0]         event_time,
   input  logic                               level_high,
   input  logic [bpgc_pkg::TimeW-1:0]         now_ms,
   input  logic [bpgc_pkg::MsW-1:0]           long_press_ms,
   input  logic [bpgc_pkg::MsW-1:0]           double_press_window_ms,
   output bpgc_pkg::adv_type                  adv
);
   import bpgc_pkg::*;

   logic [TimeW-1:0] dt;
   logic             in_window;
   logic             held_long;

   // elapsed time wraps modulo 2^32
   assign dt        = now_ms - event_time;
   assign in_window = dt < {{(TimeW-MsW){1'b0}}, double_press_window_ms};
   assign held_long = dt > {{(TimeW-MsW){1'b0}}, long_press_ms};

   always_comb begin
      adv.gesture = cur_gesture;
      adv.time_wr = 1'b0;
      if (level_high) begin
         unique case (cur_gesture)
            GEST_REST, GEST_RELEASED: begin
               if (in_window) begin
                  adv.gesture = GEST_DOUBLE;
               end else begin
                  adv.gesture = GEST_PRESSED;
                  adv.time_wr = 1'b1;
               end
            end
            GEST_PRESSED: adv.gesture = GEST_STILL;
            GEST_LONG:    adv.gesture = GEST_STILL_LONG;
            GEST_STILL: begin
               if (held_long) adv.gesture = GEST_LONG;
            end
            default: adv.gesture = cur_gesture;
         endcase
      end else begin
         unique case (cur_gesture)
            GEST_PRESSED, GEST_STILL, GEST_LONG, GEST_STILL_LONG: begin
               adv.gesture = GEST_RELEASED;
               adv.time_wr = 1'b1;
            end
            default: adv.gesture = GEST_REST;
         endcase
      end
   end

endmodule

// ===== hdl/button_press_gesture_classifier.sv =====
// Top level of the button press gesture classifier: state stores, scan and output skid stage.
//
// Takes one button sample per transfer and returns one result per sample. Throughput is one
// sample per clock while req_tready is high: the addressed button's gesture and event time
// are read, updated and written back in the cycle the sample is accepted, and the
// any/first-active scan runs over the updated gesture values in the same cycle, so the next
// sample sees the new state. An output register plus a one-entry skid buffer decouple the two
// sides; req_tready drops only while the skid entry is occupied. State resets to all
// buttons at rest with zero event times; csr writes are always accepted (csr_ready is tied high)
// and should only be issued while no result is outstanding. Indexes 0..2 select long_press_ms,
// double_press_window_ms and buttons_in_use; other indexes are ignored. Samples for a button at
// or above MAX_BUTTONS change nothing and report gesture rest.
module button_press_gesture_classifier #(
   parameter int MAX_BUTTONS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: [2:0] button_index, [3] level_high, [35:4] now_ms, [39:36] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bpgc_pkg::ReqDataW-1:0]       req_tdata,
   // response: [2:0] new_gesture, [3] any_active, [7:4] first_active
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bpgc_pkg::RspDataW-1:0]       rsp_tdata,
   // configuration write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpgc_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [bpgc_pkg::CsrDataW-1:0]       csr_data
);
   import bpgc_pkg::*;

`include "assert_macros.svh"

   // Only indexes 0..7 can arrive, so the stores never need more entries than that.
   localparam int Depth = (MAX_BUTTONS < 8) ? MAX_BUTTONS : 8;
   localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam logic [ScanW-1:0] DepthW4 = ScanW'(Depth);

   // config registers
   logic [MsW-1:0]   long_press_ff;
   logic [MsW-1:0]   double_win_ff;
   logic [ScanW-1:0] buttons_used_ff;

   // per-button state
   gesture_type      gest_ff [Depth];
   gesture_type      gest_in [Depth];
   logic [TimeW-1:0] time_ff [Depth];

   // output register and skid entry
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   logic             req_xfer;
   logic             rsp_xfer;
   logic [BtnIdxW-1:0] btn_idx;
   logic [IdxW-1:0]  btn_sel;
   logic             btn_hit;
   logic             level;
   logic [TimeW-1:0] now;
   adv_type          adv;
   rsp_type          rsp_new;

   assign btn_idx  = req_tdata[BtnIdxW-1:0];
   assign level    = req_tdata[BtnIdxW];
   assign now      = req_tdata[BtnIdxW+1 +: TimeW];
   assign btn_sel  = btn_idx[IdxW-1:0];
   assign btn_hit  = {1'b0, btn_idx} < DepthW4;

   assign req_tready = !skid_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = out_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;

   bpgc_advance u_advance (
      .cur_gesture            (gest_ff[btn_sel]),
      .event_time             (time_ff[btn_sel]),
      .level_high             (level),
      .now_ms                 (now),
      .long_press_ms          (long_press_ff),
      .double_press_window_ms (double_win_ff),
      .adv                    (adv)
   );

   // gesture store after this transfer's update; the scan looks at these values
   always_comb begin
      for (int i = 0; i < Depth; i++) begin
         gest_in[i] = gest_ff[i];
      end
      if (req_xfer && btn_hit) begin
         gest_in[btn_sel] = adv.gesture;
      end
   end

   // lowest scanned button away from rest; descending loop so the lowest wins
   always_comb begin
      rsp_new.any_active   = 1'b0;
      rsp_new.first_active = FIRST_NONE;
      rsp_new.new_gesture  = btn_hit ? adv.gesture : GEST_REST;
      for (int i = Depth - 1; i >= 0; i--) begin
         if ((buttons_used_ff > ScanW'(i)) && (gest_in[i] != GEST_REST)) begin
            rsp_new.any_active   = 1'b1;
            rsp_new.first_active = FirstW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= LONG_PRESS_RST;
         double_win_ff   <= DOUBLE_WIN_RST;
         buttons_used_ff <= BUTTONS_USED_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LONG_PRESS:   long_press_ff   <= csr_data[MsW-1:0];
            CSR_DOUBLE_WIN:   double_win_ff   <= csr_data[MsW-1:0];
            CSR_BUTTONS_USED: buttons_used_ff <= csr_data[ScanW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            gest_ff[i] <= GEST_REST;
            time_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < Depth; i++) begin
            gest_ff[i] <= gest_in[i];
         end
         if (req_xfer && btn_hit && adv.time_wr) begin
            time_ff[btn_sel] <= now;
         end
      end
   end

   // output register refills from skid first, else from the new result
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_xfer || !out_valid_ff) begin
            out_valid_ff  <= skid_valid_ff || req_xfer;
            skid_valid_ff <= 1'b0;
         end else if (req_xfer) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer || !out_valid_ff) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : rsp_new;
      end
      if (req_xfer && out_valid_ff && !rsp_xfer) begin
         skid_data_ff <= rsp_new;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // skid entry only fills behind a held output register
   `ASSERT_IMP(a_skid_behind_out, skid_valid_ff, out_valid_ff)
   // a transfer into a stalled full output must land in the skid entry
   `ASSERT_NEXT(a_stall_to_skid, req_xfer && out_valid_ff && !rsp_tready, skid_valid_ff)
   // no result is presented right after reset, and req_tready is high
   `ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid && req_tready)

endmodule
